### hw/rtl/prt_pkg.sv
package prt_pkg;

    localparam int DEF_TABLE_DEPTH  = 16;
    localparam int DEF_REASON_COUNT = 4;
    localparam int TIMEOUT_REASON   = 3;

    typedef enum logic [2:0] {
        OP_INSERT   = 3'd0,
        OP_FIND_ID  = 3'd1,
        OP_FIND_IDN = 3'd2,
        OP_DROP     = 3'd3,
        OP_SWEEP    = 3'd4,
        OP_STATUS   = 3'd5,
        OP_ALLOC    = 3'd6,
        OP_NONE     = 3'd7
    } t_opcode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINAL
    } t_state;

    typedef struct packed {
        logic        valid;
        logic [63:0] ident;
        logic [31:0] site_key;
        logic [15:0] requester;
        logic [63:0] payload_word;
        logic [15:0] payload_layout;
        logic [63:0] born_tick;
    } t_entry;

endpackage

### hw/rtl/prt_cell.sv
module prt_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_shift,
    input  prt_pkg::t_entry i_entry,
    output prt_pkg::t_entry o_entry
);
    import prt_pkg::*;

    t_entry r_entry;

    // valid bit resets; entry data is don't-care until written
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.valid <= 1'b0;
        end else if (i_shift) begin
            r_entry <= i_entry;
        end
    end

    assign o_entry = r_entry;

endmodule

### hw/rtl/pending_request_table.sv
// Table ops (insert, finds, drop, sweep) go from accept through a scan of every slot
// to a final result; status and allocate go straight to the final result.
// Throughput: one item in flight; the slot ring rotates one slot per cycle past the
// head cell, stalling only while a dropped-entry event waits on the output register.
// Reset (synchronous, active low) clears slot valid bits, high-water mark, counters,
// timeout and sets the id allocator to one.
module pending_request_table #(
    parameter int TABLE_DEPTH  = prt_pkg::DEF_TABLE_DEPTH,
    parameter int REASON_COUNT = prt_pkg::DEF_REASON_COUNT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_opcode,
    input  logic [63:0] i_pending_id,
    input  logic [31:0] i_site_key,
    input  logic [15:0] i_requester,
    input  logic [63:0] i_payload_word,
    input  logic [15:0] i_payload_layout,
    input  logic [63:0] i_tick,
    input  logic [1:0]  i_reason,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_kind,
    output logic        o_ok,
    output logic [63:0] o_value,
    output logic [4:0]  o_active_count,
    output logic [4:0]  o_free_count,
    output logic [15:0] o_event_requester,
    output logic [63:0] o_event_pending_id,
    output logic [31:0] o_event_site_key,
    output logic [1:0]  o_event_reason,
    output logic        o_last
);
    import prt_pkg::*;

    localparam int PW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int RW = (REASON_COUNT > 1) ? $clog2(REASON_COUNT) : 1;
    localparam logic [PW-1:0] LAST_POS = PW'(TABLE_DEPTH - 1);
    localparam logic TO_COUNTED = (TIMEOUT_REASON < REASON_COUNT);
    localparam logic [3:0] TO_REASON4 = 4'(TIMEOUT_REASON);

    t_state  r_state, n_state;
    t_entry  w_cell_in  [TABLE_DEPTH];
    t_entry  w_cell_out [TABLE_DEPTH];
    t_entry  w_head_next;
    t_entry  w_head;

    logic [31:0]   r_timeout;
    t_opcode       r_op;
    logic [63:0]   r_pid;
    logic [31:0]   r_key;
    logic [15:0]   r_req;
    logic [63:0]   r_pword;
    logic [15:0]   r_playout;
    logic [63:0]   r_tick;
    logic [RW-1:0] r_ridx;
    logic          r_ok;
    logic [63:0]   r_value;
    logic [PW-1:0] r_pos;
    logic [CW-1:0] r_active;
    logic [CW-1:0] r_hw;
    logic [63:0]   r_next_id;
    logic [31:0]   r_totals [REASON_COUNT];

    logic          r_ov, r_kind, r_rok, r_last;
    logic [63:0]   r_rvalue, r_epid;
    logic [CW-1:0] r_ract, r_rfree;
    logic [15:0]   r_ereq;
    logic [31:0]   r_ekey;
    logic [1:0]    r_ersn;

    logic          w_accept, w_out_free, w_shift, w_drop, w_emit, w_ins_hit, w_find_hit;
    logic          w_load_event, w_load_final;
    logic          w_status_ok, w_alloc_ok;
    logic [3:0]    w_reason4;
    logic [RW-1:0] w_to_idx;
    logic [CW-1:0] w_act_dec;
    logic [63:0]   w_age;
    logic [63:0]   w_id_inc;
    logic [6:0]    w_act7, w_free7;

    assign w_head      = w_cell_out[0];
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_out_free  = !r_ov || i_out_ready;
    assign w_reason4   = {2'b00, i_reason};
    assign w_to_idx    = TO_REASON4[RW-1:0];
    assign w_age       = r_tick - w_head.born_tick;
    assign w_act_dec   = r_active - CW'(1);
    assign w_id_inc    = r_next_id + 64'd1;
    assign w_status_ok = (w_reason4 < 4'(REASON_COUNT));
    assign w_alloc_ok  = (r_next_id != 64'd0) && (w_id_inc != 64'd0);

    // the row of cells forms a ring; the head cell is examined and refilled at the tail
    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        if (g == TABLE_DEPTH - 1) begin : g_tail
            assign w_cell_in[g] = w_head_next;
        end else begin : g_mid
            assign w_cell_in[g] = w_cell_out[g+1];
        end
        prt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_shift),
            .i_entry (w_cell_in[g]),
            .o_entry (w_cell_out[g])
        );
    end

    always_comb begin
        w_drop = 1'b0;
        if (w_head.valid && r_ok) begin
            if (r_op == OP_DROP) begin
                w_drop = (w_head.requester == r_req);
            end else if (r_op == OP_SWEEP) begin
                w_drop = (r_tick >= w_head.born_tick) && (w_age >= {32'd0, r_timeout});
            end
        end
    end

    assign w_emit     = w_drop && ((r_op == OP_DROP) || TO_COUNTED);
    assign w_ins_hit  = (r_op == OP_INSERT) && !r_ok && !w_head.valid;
    assign w_find_hit = ((r_op == OP_FIND_ID) || (r_op == OP_FIND_IDN)) && !r_ok
                        && w_head.valid && (w_head.ident == r_pid)
                        && ((r_op == OP_FIND_ID) || (w_head.site_key == r_key));

    always_comb begin
        w_head_next = w_head;
        if (w_drop) begin
            w_head_next.valid = 1'b0;
        end
        if (w_emit) begin
            w_head_next.payload_word   = '0;
            w_head_next.payload_layout = '0;
        end
        if (w_ins_hit) begin
            w_head_next.valid          = 1'b1;
            w_head_next.ident          = r_pid;
            w_head_next.site_key       = r_key;
            w_head_next.requester      = r_req;
            w_head_next.payload_word   = r_pword;
            w_head_next.payload_layout = r_playout;
            w_head_next.born_tick      = r_tick;
        end
    end

    always_comb begin
        n_state      = r_state;
        w_shift      = 1'b0;
        w_load_event = 1'b0;
        w_load_final = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_opcode <= 3'(OP_SWEEP)) begin
                        n_state = ST_SCAN;
                    end else begin
                        n_state = ST_FINAL;
                    end
                end
            end
            ST_SCAN: begin
                if (!w_emit || w_out_free) begin
                    w_shift      = 1'b1;
                    w_load_event = w_emit;
                    if (r_pos == LAST_POS) begin
                        n_state = ST_FINAL;
                    end
                end
            end
            ST_FINAL: begin
                if (w_out_free) begin
                    w_load_final = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);

    // control and counters; accept happens only in idle, shifts only while scanning
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= '0;
            r_pos     <= '0;
            r_active  <= '0;
            r_hw      <= '0;
            r_next_id <= 64'd1;
            r_ok      <= 1'b0;
            r_value   <= '0;
            r_op      <= OP_NONE;
            for (int k = 0; k < REASON_COUNT; k++) begin
                r_totals[k] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_timeout <= i_cfg_wdata;
            end
            if (w_accept) begin
                r_op  <= t_opcode'(i_opcode);
                r_pos <= '0;
                unique case (t_opcode'(i_opcode))
                    OP_DROP: begin
                        r_ok    <= w_status_ok;
                        r_value <= '0;
                    end
                    OP_SWEEP: begin
                        r_ok    <= (r_timeout != 32'd0);
                        r_value <= '0;
                    end
                    OP_STATUS: begin
                        r_ok    <= w_status_ok;
                        r_value <= w_status_ok ? {32'd0, r_totals[w_reason4[RW-1:0]]} : '0;
                    end
                    OP_ALLOC: begin
                        if (r_next_id != 64'd0) begin
                            r_next_id <= w_id_inc;
                        end
                        r_ok    <= w_alloc_ok;
                        r_value <= w_alloc_ok ? r_next_id : '0;
                    end
                    OP_INSERT, OP_FIND_ID, OP_FIND_IDN, OP_NONE: begin
                        r_ok    <= 1'b0;
                        r_value <= '0;
                    end
                    default: ;
                endcase
            end
            if (w_shift) begin
                r_pos <= r_pos + PW'(1);
                if (w_ins_hit) begin
                    r_ok     <= 1'b1;
                    r_value  <= 64'(r_pos);
                    r_active <= r_active + CW'(1);
                    if ({1'b0, r_pos} + (PW+1)'(1) > (PW+1)'(r_hw)) begin
                        r_hw <= CW'({1'b0, r_pos} + (PW+1)'(1));
                    end
                end
                if (w_find_hit) begin
                    r_ok    <= 1'b1;
                    r_value <= 64'(r_pos);
                end
                if (w_drop) begin
                    r_active <= w_act_dec;
                    r_value  <= r_value + 64'd1;
                end
                if (w_emit) begin
                    if (r_op == OP_DROP) begin
                        r_totals[r_ridx] <= r_totals[r_ridx] + 32'd1;
                    end else begin
                        r_totals[w_to_idx] <= r_totals[w_to_idx] + 32'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pid     <= i_pending_id;
            r_key     <= i_site_key;
            r_req     <= i_requester;
            r_pword   <= i_payload_word;
            r_playout <= i_payload_layout;
            r_tick    <= i_tick;
            r_ridx    <= w_reason4[RW-1:0];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_load_event || w_load_final) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_event) begin
            r_kind   <= 1'b1;
            r_rok    <= 1'b1;
            r_rvalue <= 64'(r_pos);
            r_ract   <= w_act_dec;
            r_rfree  <= r_hw - w_act_dec;
            r_ereq   <= w_head.requester;
            r_epid   <= w_head.ident;
            r_ekey   <= w_head.site_key;
            r_ersn   <= (r_op == OP_DROP) ? 2'(r_ridx) : 2'(TIMEOUT_REASON);
            r_last   <= 1'b0;
        end else if (w_load_final) begin
            r_kind   <= 1'b0;
            r_rok    <= r_ok;
            r_rvalue <= r_value;
            r_ract   <= r_active;
            r_rfree  <= r_hw - r_active;
            r_ereq   <= '0;
            r_epid   <= '0;
            r_ekey   <= '0;
            r_ersn   <= '0;
            r_last   <= 1'b1;
        end
    end

    assign w_act7  = 7'(r_ract);
    assign w_free7 = 7'(r_rfree);

    assign o_out_valid        = r_ov;
    assign o_kind             = r_kind;
    assign o_ok               = r_rok;
    assign o_value            = r_rvalue;
    assign o_active_count     = w_act7[4:0];
    assign o_free_count       = w_free7[4:0];
    assign o_event_requester  = r_ereq;
    assign o_event_pending_id = r_epid;
    assign o_event_site_key   = r_ekey;
    assign o_event_reason     = r_ersn;
    assign o_last             = r_last;

endmodule

### hw/rtl/prt_checker.sv
module prt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic        o_kind,
    input logic        o_ok,
    input logic [63:0] o_value,
    input logic        o_last
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_value))
        else $error("stalled output item changed");

    a_kind_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_kind != o_last))
        else $error("event and final marks disagree");

    a_event_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind |-> o_ok)
        else $error("event without ok");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second item taken while busy");

endmodule

bind pending_request_table prt_checker u_prt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_kind      (o_kind),
    .o_ok        (o_ok),
    .o_value     (o_value),
    .o_last      (o_last)
);
